// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the keypad decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication in the same cycle.
`define AKD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication in the following cycle.
`define AKD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define AKD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AKD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// akd_pkg
// Types and ladder tables for the ADC ladder keypad decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package akd_pkg;

  localparam int LADDER_STEPS = 7;
  localparam int KEY_MAP_VARIANT_DEFAULT = 0;

  typedef logic [2:0] key_t;
  typedef logic [7:0] adc_t;

  localparam key_t KEY_NONE      = 3'd0;
  localparam key_t KEY_BACKLIGHT = 3'd1;

  localparam logic [1:0] MAP_SEL_LADDER2 = 2'd2;

  localparam adc_t THR_TAB [2][LADDER_STEPS] = '{
    '{8'd113, 8'd92, 8'd72, 8'd52, 8'd33, 8'd12, 8'd0},
    '{8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106, 8'd94}
  };

  localparam key_t MAP_TAB [3][LADDER_STEPS] = '{
    '{3'd0, 3'd7, 3'd5, 3'd4, 3'd6, 3'd2, 3'd1},
    '{3'd0, 3'd4, 3'd2, 3'd1, 3'd6, 3'd7, 3'd5},
    '{3'd0, 3'd6, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2}
  };

  typedef struct packed {
    logic release_hit;
    logic hit;
    key_t cand;
  } cls_t;

  typedef struct packed {
    key_t key_code;
    logic key_fault;
    logic backlight_request;
  } res_t;

endpackage

// ===== rtl/akd_classify.sv =====
// ----------------------------------------------------------------------------
// akd_classify
// Compares a sample against the selected threshold ladder and maps the
// highest threshold reached to a key candidate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module akd_classify #(
  parameter int KEY_MAP_VARIANT = akd_pkg::KEY_MAP_VARIANT_DEFAULT
) (
  input  akd_pkg::adc_t adc_code,
  input  logic          table_select,
  output akd_pkg::cls_t cls
);

  logic [akd_pkg::LADDER_STEPS-1:0] ge;
  logic [1:0]                       map_sel;

  assign map_sel = table_select ? akd_pkg::MAP_SEL_LADDER2
                                : {1'b0, 1'(KEY_MAP_VARIANT)};

  always_comb begin
    for (int i = 0; i < akd_pkg::LADDER_STEPS; i++) begin
      ge[i] = adc_code >= akd_pkg::THR_TAB[table_select][i];
    end
  end

  always_comb begin
    cls.release_hit = ge[0];
    cls.hit         = |ge;
    cls.cand        = akd_pkg::KEY_NONE;
    for (int i = akd_pkg::LADDER_STEPS - 1; i >= 0; i--) begin
      if (ge[i]) begin
        cls.cand = akd_pkg::MAP_TAB[map_sel][i];
      end
    end
  end

endmodule

// ===== rtl/akd_state.sv =====
// ----------------------------------------------------------------------------
// akd_state
// Debounce, lock and fault state of the keypad decoder, and the result
// that each sample produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module akd_state (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  akd_pkg::cls_t cls,
  input  logic          standby,
  input  logic          backlight_on,
  output akd_pkg::res_t res
);

  logic          locked_r, locked_nxt;
  logic          fault_r, fault_nxt;
  akd_pkg::key_t prev_r, prev_nxt;
  akd_pkg::key_t acc_r, acc_nxt;
  akd_pkg::key_t held_r, held_nxt;
  logic          req;
  logic          lit;

  always_comb begin
    locked_nxt = locked_r;
    fault_nxt  = fault_r;
    prev_nxt   = prev_r;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    req        = 1'b0;
    lit        = backlight_on;
    if (cls.release_hit) begin
      locked_nxt = 1'b0;
      fault_nxt  = 1'b0;
      prev_nxt   = akd_pkg::KEY_NONE;
      acc_nxt    = akd_pkg::KEY_NONE;
      held_nxt   = akd_pkg::KEY_NONE;
    end else if (!locked_r && cls.hit) begin
      if (prev_r != cls.cand) begin
        prev_nxt = cls.cand;
      end else if (acc_r == akd_pkg::KEY_NONE || cls.cand == acc_r) begin
        acc_nxt = cls.cand;
        if (cls.cand == akd_pkg::KEY_BACKLIGHT && !standby) begin
          lit = 1'b1;
          req = 1'b1;
        end
        if (!lit) begin
          if (standby) begin
            locked_nxt = 1'b1;
            req        = 1'b1;
            held_nxt   = akd_pkg::KEY_NONE;
          end
        end else begin
          held_nxt = cls.cand;
        end
      end else begin
        locked_nxt = 1'b1;
        fault_nxt  = 1'b1;
        held_nxt   = akd_pkg::KEY_NONE;
      end
    end
    res.key_code          = held_nxt;
    res.key_fault         = fault_nxt;
    res.backlight_request = req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      fault_r  <= 1'b0;
      prev_r   <= akd_pkg::KEY_NONE;
      acc_r    <= akd_pkg::KEY_NONE;
      held_r   <= akd_pkg::KEY_NONE;
    end else if (step) begin
      locked_r <= locked_nxt;
      fault_r  <= fault_nxt;
      prev_r   <= prev_nxt;
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
    end
  end

  `AKD_ASSERT_IMP(a_fault_locks, clk, rst_n, fault_r, locked_r)
  `AKD_ASSERT_IMP(a_fault_no_key, clk, rst_n, fault_r, held_r == akd_pkg::KEY_NONE)
  `AKD_ASSERT_NEXT(a_release_unlocks, clk, rst_n, step && cls.release_hit, !locked_r && !fault_r)
  `AKD_ASSERT_NEXT(a_idle_holds, clk, rst_n, !step, $stable(acc_r) && $stable(held_r))

endmodule

// ===== rtl/adc_ladder_key_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_unit
// Resistor-ladder keypad decoder with debounce, lock and backlight logic.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word carries one keypad ADC sample with the standby and
//   backlight flags; each output word carries the held key, the fault flag
//   and the backlight request for that sample. Both channels use
//   valid/ready. The ladder table is chosen through cfg_we/cfg_table_select
//   by the user, who must do so only while the block is idle; the block does
//   not enforce this. A word is captured in an input register, decoded by
//   the threshold compares and state update, and lands in the output
//   register when it advances. One word per cycle is sustained while
//   out_ready is high; the single state update per sample sets that figure.
//   While the receiver stalls, the output register holds its word and the
//   input register still accepts one more word; then in_ready drops until
//   the output drains.
//   Reset clears the table select, all key state and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_ladder_key_decoder_unit #(
  parameter int KEY_MAP_VARIANT = akd_pkg::KEY_MAP_VARIANT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_table_select,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_adc_code,
  input  logic       in_standby,
  input  logic       in_backlight_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_key_code,
  output logic       out_key_fault,
  output logic       out_backlight_request
);

  logic          table_select_r;
  logic          in_valid_r;
  akd_pkg::adc_t adc_r;
  logic          standby_r;
  logic          backlight_r;
  logic          out_valid_r;
  akd_pkg::res_t out_r;
  logic          advance;
  akd_pkg::cls_t cls;
  akd_pkg::res_t res;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_select_r <= 1'b0;
    end else if (cfg_we) begin
      table_select_r <= cfg_table_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      adc_r       <= in_adc_code;
      standby_r   <= in_standby;
      backlight_r <= in_backlight_on;
    end
  end

  akd_classify #(
    .KEY_MAP_VARIANT(KEY_MAP_VARIANT)
  ) u_classify (
    .adc_code    (adc_r),
    .table_select(table_select_r),
    .cls         (cls)
  );

  akd_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .cls         (cls),
    .standby     (standby_r),
    .backlight_on(backlight_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_key_code          = out_r.key_code;
  assign out_key_fault         = out_r.key_fault;
  assign out_backlight_request = out_r.backlight_request;

endmodule

// ===== bench/adc_ladder_key_decoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_unit_test
// Self-checking bench for the resistor-ladder keypad decoder. A scoreboard
// predicts the held key, fault and backlight request of every sample and
// compares each output word in order. Directed presses, releases, conflicts
// and standby cases run first, then random press sequences on both ladder
// tables with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_ladder_key_decoder_unit_test;

  localparam int KEY_VARIANT   = 0;
  localparam int STEPS         = 7;
  localparam int IDLE_LIMIT    = 1000;
  localparam int RANDOM_WORDS  = 450;
  localparam int MAX_SHOWN     = 10;

  localparam akd_pkg::adc_t LADDER_THRESH [2][STEPS] = '{
    '{8'd113, 8'd92, 8'd72, 8'd52, 8'd33, 8'd12, 8'd0},
    '{8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106, 8'd94}
  };

  localparam akd_pkg::key_t LADDER_KEYS [3][STEPS] = '{
    '{3'd0, 3'd7, 3'd5, 3'd4, 3'd6, 3'd2, 3'd1},
    '{3'd0, 3'd4, 3'd2, 3'd1, 3'd6, 3'd7, 3'd5},
    '{3'd0, 3'd6, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2}
  };

  typedef struct packed {
    akd_pkg::key_t key;
    logic          fault;
    logic          request;
  } keypad_word_t;

  class keypad_scoreboard;
    bit            ladder_sel;
    bit            locked;
    akd_pkg::key_t last_cand;
    akd_pkg::key_t confirmed_key;
    akd_pkg::key_t held_key;
    bit            fault;
    keypad_word_t  pending[$];
    int            words_checked;
    int            mismatches;
    int            faults_seen;
    int            requests_seen;

    function void clear_keys();
      locked        = 0;
      last_cand     = '0;
      confirmed_key = '0;
      held_key      = '0;
      fault         = 0;
    endfunction

    function void note_sample(akd_pkg::adc_t adc, bit standby, bit lit);
      int            map_row;
      bit            req;
      bit            lamp;
      bit            hit;
      akd_pkg::key_t cand;
      keypad_word_t  w;
      map_row = ladder_sel ? 2 : (KEY_VARIANT & 1);
      req = 0;
      hit = 0;
      if (adc >= LADDER_THRESH[ladder_sel][0]) begin
        clear_keys();
      end else if (!locked) begin
        for (int i = 0; i < STEPS && !hit; i++) begin
          if (adc >= LADDER_THRESH[ladder_sel][i]) begin
            hit = 1;
            cand = LADDER_KEYS[map_row][i];
            if (last_cand != cand) begin
              last_cand = cand;
            end else if (confirmed_key == 0 || cand == confirmed_key) begin
              lamp = lit;
              confirmed_key = cand;
              if (cand == akd_pkg::KEY_BACKLIGHT && !standby) begin
                lamp = 1;
                req = 1;
              end
              if (!lamp) begin
                if (standby) begin
                  locked = 1;
                  req = 1;
                  held_key = '0;
                end
              end else begin
                held_key = cand;
              end
            end else begin
              locked = 1;
              held_key = '0;
              fault = 1;
            end
          end
        end
      end
      w.key = held_key;
      w.fault = fault;
      w.request = req;
      if (fault) faults_seen++;
      if (req) requests_seen++;
      pending.push_back(w);
    endfunction

    function void check_word(akd_pkg::key_t key, bit flt, bit req);
      keypad_word_t want;
      if (pending.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("Unexpected output word: key %0d fault %0d request %0d", key, flt, req);
        mismatches++;
      end else begin
        want = pending.pop_front();
        words_checked++;
        if (want.key !== key || want.fault !== flt || want.request !== req) begin
          if (mismatches < MAX_SHOWN)
            $display("Word %0d mismatch: expected key %0d fault %0d request %0d,",
                     words_checked, want.key, want.fault, want.request,
                     " got %0d %0d %0d", key, flt, req);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_table_select;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_adc_code;
  logic       in_standby;
  logic       in_backlight_on;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_key_code;
  logic       out_key_fault;
  logic       out_backlight_request;

  keypad_scoreboard board;
  bit               calm;
  int               samples_sent;
  int               idle_cycles;

  adc_ladder_key_decoder_unit #(
    .KEY_MAP_VARIANT(KEY_VARIANT)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_table_select     (cfg_table_select),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_adc_code          (in_adc_code),
    .in_standby           (in_standby),
    .in_backlight_on      (in_backlight_on),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_key_code         (out_key_code),
    .out_key_fault        (out_key_fault),
    .out_backlight_request(out_backlight_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk) begin
    if (rst_n && board != null) begin
      if (in_valid && in_ready) board.note_sample(in_adc_code, in_standby, in_backlight_on);
      if (out_valid && out_ready)
        board.check_word(out_key_code, out_key_fault, out_backlight_request);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int g;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_sample(akd_pkg::adc_t adc, bit standby, bit lit);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_adc_code     <= adc;
    in_standby      <= standby;
    in_backlight_on <= lit;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic press_twice(akd_pkg::adc_t adc, bit standby, bit lit);
    send_sample(adc, standby, lit);
    send_sample(adc, standby, lit);
  endtask

  task automatic drain_and_select(bit sel);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we           <= 1'b1;
    cfg_table_select <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.ladder_sel = sel;
  endtask

  function automatic akd_pkg::adc_t band_value(bit sel, int step);
    int lo;
    int hi;
    lo = LADDER_THRESH[sel][step];
    hi = (step == 0) ? 255 : LADDER_THRESH[sel][step - 1] - 1;
    return akd_pkg::adc_t'($urandom_range(lo, hi));
  endfunction

  task automatic random_phase(int count);
    int   stop_at;
    int   r;
    int   step;
    int   other;
    int   reps;
    bit   sel;
    bit   standby;
    bit   lit;
    stop_at = samples_sent + count;
    sel = board.ladder_sel;
    while (samples_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        step = $urandom_range(1, STEPS - 1);
        standby = ($urandom_range(0, 3) == 0);
        lit = ($urandom_range(0, 3) != 0);
        reps = $urandom_range(1, 4);
        for (int k = 0; k < reps; k++) begin
          if ($urandom_range(0, 7) == 0) standby = ~standby;
          if ($urandom_range(0, 7) == 0) lit = ~lit;
          send_sample(band_value(sel, step), standby, lit);
        end
        if ($urandom_range(0, 3) == 0) begin
          other = $urandom_range(1, STEPS - 1);
          send_sample(band_value(sel, other), standby, lit);
          send_sample(band_value(sel, other), standby, lit);
        end
        if ($urandom_range(0, 4) != 0) send_sample(band_value(sel, 0), standby, lit);
      end else if (r < 8 && sel) begin
        send_sample(akd_pkg::adc_t'($urandom_range(0, 93)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < 9) begin
        send_sample(akd_pkg::adc_t'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_sample(band_value(sel, 0),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    samples_sent     = 0;
    calm             = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_table_select <= 1'b0;
    in_valid         <= 1'b0;
    in_adc_code      <= '0;
    in_standby       <= 1'b0;
    in_backlight_on  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    board = new();
    board.clear_keys();
    board.ladder_sel = 0;
    @(posedge clk);

    drain_and_select(1'b0);
    send_sample(8'd255, 0, 1);
    send_sample(8'd113, 0, 1);
    press_twice(8'd112, 0, 1);
    send_sample(8'd92, 0, 1);
    press_twice(8'd91, 0, 1);
    send_sample(8'd50, 0, 1);
    send_sample(8'd113, 0, 1);
    press_twice(8'd0, 0, 0);
    send_sample(8'd200, 1, 0);
    press_twice(8'd33, 1, 0);
    send_sample(8'd120, 0, 1);
    press_twice(8'd12, 0, 0);
    press_twice(8'd72, 1, 1);

    drain_and_select(1'b1);
    send_sample(8'd93, 0, 1);
    press_twice(8'd189, 0, 1);
    send_sample(8'd190, 0, 1);
    press_twice(8'd94, 0, 1);
    send_sample(8'd255, 0, 0);
    press_twice(8'd106, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_select(phase[0]);
      calm = (phase == 2);
      random_phase(RANDOM_WORDS);
    end
    calm = 0;

    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d samples over both ladder tables; %0d output words checked.",
             samples_sent, board.words_checked);
    $display("Predicted %0d words with the fault flag and %0d backlight requests.",
             board.faults_seen, board.requests_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words still expected", board.mismatches,
               board.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
